/* hdl/ipv4hv_pkg.sv */
// Shared types, codes and constants of the IPv4 header validator.
`timescale 1ns / 1ps
`default_nettype none

package ipv4hv_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index as seen in paddr[2]
  localparam logic REG_LOCAL_IP = 1'b0;

  localparam logic [15:0] MIN_HDR    = 16'd20;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam logic [15:0] FRAG_MASK  = 16'h3FFF;
  localparam logic [15:0] SUM_GOOD   = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_TCP  = 8'd6;

  typedef enum logic [2:0] {
    V_ACCEPT    = 3'd0,
    V_RUNT      = 3'd1,
    V_VERSION   = 3'd2,
    V_IHL       = 3'd3,
    V_CHECKSUM  = 3'd4,
    V_TOTAL_LEN = 3'd5,
    V_NOT_OURS  = 3'd6,
    V_FRAGMENT  = 3'd7
  } verdict_t;

  typedef enum logic [1:0] {
    T_ICMP  = 2'd0,
    T_UDP   = 2'd1,
    T_TCP   = 2'd2,
    T_OTHER = 2'd3
  } transport_t;

  // Header state of one complete frame, taken at its last byte
  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] sum;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [15:0] frag_field;
    logic [7:0]  proto_num;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
  } frame_sum_t;

  typedef struct packed {
    verdict_t    verdict;
    transport_t  transport;
    logic [7:0]  protocol;
    logic [31:0] source_addr;
    logic [5:0]  header_len;
    logic [15:0] payload_len;
  } verdict_res_t;

endpackage

`default_nettype wire

/* hdl/ipv4hv_if.sv */
// Stream interfaces: datagram bytes in, verdicts out.
`timescale 1ns / 1ps
`default_nettype none

interface ipv4hv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4hv_verdict_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [1:0]  transport;
  logic [7:0]  protocol;
  logic [31:0] source_addr;
  logic [5:0]  header_len;
  logic [15:0] payload_len;

  modport source (output valid, output verdict, output transport, output protocol,
                  output source_addr, output header_len, output payload_len,
                  input ready);
  modport sink   (input valid, input verdict, input transport, input protocol,
                  input source_addr, input header_len, input payload_len,
                  output ready);
endinterface

`default_nettype wire

/* hdl/ipv4_header_validator.sv */
// Top level of the IPv4 header validator: byte capture, checksum, result register.
`timescale 1ns / 1ps
`default_nettype none

// Receives an IPv4 datagram one byte per transfer on frame (last_byte marks the
// final byte) and returns one verdict per frame on report. A byte is taken every
// cycle while report keeps up; the per-byte path is a single 16-bit ones'-complement
// add with end-around carry. At its last byte a frame's header state is latched, and
// the checks on it are then registered. Two frames' verdicts can be held while
// report is stalled; after that frame.ready drops. local_ip is written over APB at
// byte address 0 (paddr[2] low) and must only be changed while no frame is in
// flight. No clearing pass after reset.
module ipv4_header_validator (
  input  var logic                               clk,
  input  var logic                               rst,
  ipv4hv_byte_if.sink                            frame,
  ipv4hv_verdict_if.source                       report,
  input  var logic                               psel,
  input  var logic                               penable,
  input  var logic                               pwrite,
  input  var logic [ipv4hv_pkg::APB_ADDR_W-1:0]  paddr,
  input  var logic [ipv4hv_pkg::APB_DATA_W-1:0]  pwdata,
  output var logic [ipv4hv_pkg::APB_DATA_W-1:0]  prdata,
  output var logic                               pready
);

  localparam logic [15:0] POS_VER_IHL = 16'd0;
  localparam logic [15:0] POS_TLEN_HI = 16'd2;
  localparam logic [15:0] POS_TLEN_LO = 16'd3;
  localparam logic [15:0] POS_FRAG_HI = 16'd6;
  localparam logic [15:0] POS_FRAG_LO = 16'd7;
  localparam logic [15:0] POS_PROTO   = 16'd9;
  localparam logic [15:0] POS_SRC_0   = 16'd12;
  localparam logic [15:0] POS_SRC_1   = 16'd13;
  localparam logic [15:0] POS_SRC_2   = 16'd14;
  localparam logic [15:0] POS_SRC_3   = 16'd15;
  localparam logic [15:0] POS_DST_0   = 16'd16;
  localparam logic [15:0] POS_DST_1   = 16'd17;
  localparam logic [15:0] POS_DST_2   = 16'd18;
  localparam logic [15:0] POS_DST_3   = 16'd19;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // ---------------- configuration ----------------
  logic [31:0] local_ip;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ipv4hv_pkg::REG_LOCAL_IP) begin
      local_ip <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ipv4hv_pkg::REG_LOCAL_IP) begin
      prdata = local_ip;
    end
  end

  // ---------------- per-byte state ----------------
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] sum_accum, sum_accum_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] frag_field, frag_field_next;
  logic [7:0]  proto_num, proto_num_next;
  logic [31:0] src_addr_reg, src_addr_reg_next;
  logic [31:0] dst_addr_reg, dst_addr_reg_next;

  logic        saturated;
  logic        in_hdr;
  logic [5:0]  hdr_len_next;
  logic [7:0]  b;
  logic        in_xfer;
  logic        last_xfer;

  logic                   snap_valid;
  ipv4hv_pkg::frame_sum_t snap;
  logic                   out_valid;
  ipv4hv_pkg::verdict_res_t result;
  ipv4hv_pkg::verdict_res_t verdict_res;
  logic                   out_adv;

  assign b         = frame.data_byte;
  assign saturated = (byte_count == ipv4hv_pkg::COUNT_MAX);
  assign out_adv   = !out_valid || report.ready;
  assign frame.ready = !snap_valid || out_adv;
  assign in_xfer   = frame.valid && frame.ready;
  assign last_xfer = in_xfer && frame.last_byte;

  // Field capture by byte position
  always_comb begin
    version_ihl_next  = version_ihl;
    total_length_next = total_length;
    frag_field_next   = frag_field;
    proto_num_next    = proto_num;
    src_addr_reg_next = src_addr_reg;
    dst_addr_reg_next = dst_addr_reg;
    if (!saturated) begin
      case (byte_count)
        POS_VER_IHL: version_ihl_next        = b;
        POS_TLEN_HI: total_length_next[15:8] = b;
        POS_TLEN_LO: total_length_next[7:0]  = b;
        POS_FRAG_HI: frag_field_next[15:8]   = b;
        POS_FRAG_LO: frag_field_next[7:0]    = b;
        POS_PROTO:   proto_num_next          = b;
        POS_SRC_0:   src_addr_reg_next[31:24] = b;
        POS_SRC_1:   src_addr_reg_next[23:16] = b;
        POS_SRC_2:   src_addr_reg_next[15:8]  = b;
        POS_SRC_3:   src_addr_reg_next[7:0]   = b;
        POS_DST_0:   dst_addr_reg_next[31:24] = b;
        POS_DST_1:   dst_addr_reg_next[23:16] = b;
        POS_DST_2:   dst_addr_reg_next[15:8]  = b;
        POS_DST_3:   dst_addr_reg_next[7:0]   = b;
        default: ;
      endcase
    end
  end

  // Checksum runs over the header length known after this byte, so byte 0 counts
  assign hdr_len_next = {version_ihl_next[3:0], 2'b00};
  assign in_hdr       = !saturated && (byte_count < {10'd0, hdr_len_next});

  always_comb begin
    high_byte_hold_next = high_byte_hold;
    sum_accum_next      = sum_accum;
    if (in_hdr) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = b;
      end else begin
        sum_accum_next = oc_add(sum_accum, {high_byte_hold, b});
      end
    end
    byte_count_next = saturated ? byte_count : byte_count + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      sum_accum      <= '0;
      high_byte_hold <= '0;
      version_ihl    <= '0;
      total_length   <= '0;
      frag_field     <= '0;
      proto_num      <= '0;
      src_addr_reg   <= '0;
      dst_addr_reg   <= '0;
    end else if (in_xfer) begin
      high_byte_hold <= high_byte_hold_next;
      version_ihl    <= version_ihl_next;
      total_length   <= total_length_next;
      frag_field     <= frag_field_next;
      proto_num      <= proto_num_next;
      src_addr_reg   <= src_addr_reg_next;
      dst_addr_reg   <= dst_addr_reg_next;
      if (frame.last_byte) begin
        byte_count <= '0;
        sum_accum  <= '0;
      end else begin
        byte_count <= byte_count_next;
        sum_accum  <= sum_accum_next;
      end
    end
  end

  // ---------------- frame snapshot and result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (last_xfer) begin
      snap_valid <= 1'b1;
    end else if (snap_valid && out_adv) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_xfer) begin
      snap.frame_len    <= byte_count_next;
      snap.sum          <= sum_accum_next;
      snap.version_ihl  <= version_ihl_next;
      snap.total_length <= total_length_next;
      snap.frag_field   <= frag_field_next;
      snap.proto_num    <= proto_num_next;
      snap.src_addr     <= src_addr_reg_next;
      snap.dst_addr     <= dst_addr_reg_next;
    end
  end

  ipv4hv_verdict u_verdict (
    .frame_sum (snap),
    .local_ip  (local_ip),
    .result    (verdict_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && snap_valid) begin
      result <= verdict_res;
    end
  end

  assign report.valid       = out_valid;
  assign report.verdict     = result.verdict;
  assign report.transport   = result.transport;
  assign report.protocol    = result.protocol;
  assign report.source_addr = result.source_addr;
  assign report.header_len  = result.header_len;
  assign report.payload_len = result.payload_len;

`ifndef SYNTHESIS
  // A rejected frame carries only its verdict
  a_reject_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.verdict != ipv4hv_pkg::V_ACCEPT) |->
      (result.transport == ipv4hv_pkg::T_ICMP && result.protocol == 8'd0 &&
       result.source_addr == 32'd0 && result.header_len == 6'd0 &&
       result.payload_len == 16'd0))
    else $error("rejected verdict with nonzero fields");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    last_xfer |=> (byte_count == 16'd0 && sum_accum == 16'd0))
    else $error("byte count or sum not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !frame.last_byte && !saturated) |=>
      (byte_count == $past(byte_count) + 16'd1))
    else $error("byte count did not advance");

  a_last_snap: assert property (@(posedge clk) disable iff (rst)
    last_xfer |=> snap_valid)
    else $error("last byte did not produce a pending verdict");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !out_adv) |-> !frame.ready)
    else $error("input taken while pending verdict is blocked");
`endif

endmodule

`default_nettype wire

/* hdl/ipv4hv_verdict.sv */
// Verdict logic: ordered receive checks over one frame's captured header.
`timescale 1ns / 1ps
`default_nettype none

module ipv4hv_verdict (
  input  var ipv4hv_pkg::frame_sum_t   frame_sum,
  input  var logic [31:0]              local_ip,
  output var ipv4hv_pkg::verdict_res_t result
);

  logic [3:0]  ihl;
  logic [5:0]  hdr_len;
  logic [15:0] hdr_len_w;
  ipv4hv_pkg::verdict_t verdict;

  assign ihl       = frame_sum.version_ihl[3:0];
  assign hdr_len   = {ihl, 2'b00};
  assign hdr_len_w = {10'd0, hdr_len};

  always_comb begin
    if (frame_sum.frame_len < ipv4hv_pkg::MIN_HDR) begin
      verdict = ipv4hv_pkg::V_RUNT;
    end else if (frame_sum.version_ihl[7:4] != ipv4hv_pkg::IP_VERSION) begin
      verdict = ipv4hv_pkg::V_VERSION;
    end else if (ihl < ipv4hv_pkg::IHL_MIN || hdr_len_w > frame_sum.frame_len) begin
      verdict = ipv4hv_pkg::V_IHL;
    end else if (frame_sum.sum != ipv4hv_pkg::SUM_GOOD) begin
      verdict = ipv4hv_pkg::V_CHECKSUM;
    end else if (frame_sum.total_length < hdr_len_w ||
                 frame_sum.total_length > frame_sum.frame_len) begin
      verdict = ipv4hv_pkg::V_TOTAL_LEN;
    end else if (frame_sum.dst_addr != local_ip) begin
      verdict = ipv4hv_pkg::V_NOT_OURS;
    end else if ((frame_sum.frag_field & ipv4hv_pkg::FRAG_MASK) != 16'd0) begin
      verdict = ipv4hv_pkg::V_FRAGMENT;
    end else begin
      verdict = ipv4hv_pkg::V_ACCEPT;
    end
  end

  always_comb begin
    result         = '0;
    result.verdict = verdict;
    if (verdict == ipv4hv_pkg::V_ACCEPT) begin
      case (frame_sum.proto_num)
        ipv4hv_pkg::PROTO_ICMP: result.transport = ipv4hv_pkg::T_ICMP;
        ipv4hv_pkg::PROTO_UDP:  result.transport = ipv4hv_pkg::T_UDP;
        ipv4hv_pkg::PROTO_TCP:  result.transport = ipv4hv_pkg::T_TCP;
        default:                result.transport = ipv4hv_pkg::T_OTHER;
      endcase
      result.protocol    = frame_sum.proto_num;
      result.source_addr = frame_sum.src_addr;
      result.header_len  = hdr_len;
      result.payload_len = frame_sum.total_length - hdr_len_w;
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for the IPv4 header validator: a shadow predictor checks every verdict.
`timescale 1ns / 1ps

module tb;

  typedef logic [7:0] octet_q_t[$];

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 60;
  localparam logic [ipv4hv_pkg::APB_ADDR_W-1:0] LOCAL_IP_ADDR =
    {ipv4hv_pkg::REG_LOCAL_IP, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ipv4hv_pkg::APB_ADDR_W-1:0] paddr;
  logic [ipv4hv_pkg::APB_DATA_W-1:0] pwdata;
  logic [ipv4hv_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  ipv4hv_byte_if    frame_if ();
  ipv4hv_verdict_if report_if ();

  ipv4_header_validator dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_if),
    .report  (report_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block's header state
  logic [15:0] ip_count = '0;
  logic [15:0] ip_sum   = '0;
  logic [7:0]  ip_hold  = '0;
  logic [7:0]  ip_vihl  = '0;
  logic [15:0] ip_tlen  = '0;
  logic [15:0] ip_frag  = '0;
  logic [7:0]  ip_proto = '0;
  logic [31:0] ip_src   = '0;
  logic [31:0] ip_dst   = '0;
  logic [31:0] local_ip_shadow = '0;

  ipv4hv_pkg::verdict_res_t pending_verdicts[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  logic report_hold = 1'b0;
  event hold_start;

  int mismatch_count = 0;
  int bytes_taken = 0;
  int verdicts_seen = 0;
  int ip_settings = 0;
  int verdict_hist[8];
  int quiet_cycles = 0;

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want, got);
    end
  endtask

  // Advance the header state by one byte; on the last byte, queue the verdict
  task automatic ipv4_check_byte(input logic [7:0] b, input logic l);
    int pos;
    logic [15:0] hdr_bytes;
    logic [16:0] acc;
    ipv4hv_pkg::verdict_t v;
    ipv4hv_pkg::verdict_res_t r;
    pos = int'(ip_count);
    if (ip_count != ipv4hv_pkg::COUNT_MAX) begin
      case (pos)
        0: ip_vihl = b;
        2: ip_tlen[15:8] = b;
        3: ip_tlen[7:0] = b;
        6: ip_frag[15:8] = b;
        7: ip_frag[7:0] = b;
        9: ip_proto = b;
        12, 13, 14, 15: ip_src[8*(15-pos) +: 8] = b;
        16, 17, 18, 19: ip_dst[8*(19-pos) +: 8] = b;
        default: ;
      endcase
      hdr_bytes = {10'd0, ip_vihl[3:0], 2'b00};
      if (ip_count < hdr_bytes) begin
        if (!ip_count[0]) begin
          ip_hold = b;
        end else begin
          acc = {1'b0, ip_sum} + {1'b0, ip_hold, b};
          ip_sum = acc[15:0] + {15'd0, acc[16]};
        end
      end
      ip_count = ip_count + 16'd1;
    end
    if (l) begin
      hdr_bytes = {10'd0, ip_vihl[3:0], 2'b00};
      if (ip_count < ipv4hv_pkg::MIN_HDR)
        v = ipv4hv_pkg::V_RUNT;
      else if (ip_vihl[7:4] != ipv4hv_pkg::IP_VERSION)
        v = ipv4hv_pkg::V_VERSION;
      else if (ip_vihl[3:0] < ipv4hv_pkg::IHL_MIN || hdr_bytes > ip_count)
        v = ipv4hv_pkg::V_IHL;
      else if (ip_sum != ipv4hv_pkg::SUM_GOOD)
        v = ipv4hv_pkg::V_CHECKSUM;
      else if (ip_tlen < hdr_bytes || ip_tlen > ip_count)
        v = ipv4hv_pkg::V_TOTAL_LEN;
      else if (ip_dst != local_ip_shadow)
        v = ipv4hv_pkg::V_NOT_OURS;
      else if ((ip_frag & ipv4hv_pkg::FRAG_MASK) != 16'h0)
        v = ipv4hv_pkg::V_FRAGMENT;
      else
        v = ipv4hv_pkg::V_ACCEPT;
      r = '0;
      r.verdict = v;
      if (v == ipv4hv_pkg::V_ACCEPT) begin
        case (ip_proto)
          ipv4hv_pkg::PROTO_ICMP: r.transport = ipv4hv_pkg::T_ICMP;
          ipv4hv_pkg::PROTO_UDP:  r.transport = ipv4hv_pkg::T_UDP;
          ipv4hv_pkg::PROTO_TCP:  r.transport = ipv4hv_pkg::T_TCP;
          default:                r.transport = ipv4hv_pkg::T_OTHER;
        endcase
        r.protocol    = ip_proto;
        r.source_addr = ip_src;
        r.header_len  = hdr_bytes[5:0];
        r.payload_len = ip_tlen - hdr_bytes;
      end
      pending_verdicts.push_back(r);
      ip_count = '0;
      ip_sum = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && frame_if.valid && frame_if.ready) begin
      bytes_taken++;
      ipv4_check_byte(frame_if.data_byte, frame_if.last_byte);
    end
  end

  always @(posedge clk) begin
    ipv4hv_pkg::verdict_res_t e;
    if (!rst && report_if.valid && report_if.ready) begin
      verdicts_seen++;
      verdict_hist[report_if.verdict]++;
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t: verdict transfer: expected none, got verdict %0d", $time,
                 report_if.verdict);
      end else begin
        e = pending_verdicts.pop_front();
        check_field("verdict", e.verdict, report_if.verdict);
        check_field("transport", e.transport, report_if.transport);
        check_field("protocol", e.protocol, report_if.protocol);
        check_field("source_addr", e.source_addr, report_if.source_addr);
        check_field("header_len", e.header_len, report_if.header_len);
        check_field("payload_len", e.payload_len, report_if.payload_len);
      end
    end
  end

  always @(posedge clk)
    report_if.ready <= !report_hold && ($urandom_range(99) >= sink_idle_pct);

  // Long receiver stall, counted here so the sender keeps pushing
  initial begin
    forever begin
      @(hold_start);
      report_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      report_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (frame_if.valid && frame_if.ready) ||
        (report_if.valid && report_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d verdicts still outstanding", $time,
                 pending_verdicts.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid     <= 1'b1;
    frame_if.data_byte <= b;
    frame_if.last_byte <= l;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
  endtask

  task automatic send_dgram(input octet_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Drop valid, wait for every verdict, then let the pipeline drain
  task automatic settle();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LOCAL_IP_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_local_ip(input logic [31:0] addr);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, rd);
    local_ip_shadow = addr;
    ip_settings++;
    apb_xfer(1'b0, 32'h0, rd);
    check_field("local_ip readback", local_ip_shadow, rd);
  endtask

  function automatic octet_q_t build_dgram(input logic [3:0] ver, input logic [3:0] ihl,
                                           input logic [7:0] proto, input logic [15:0] frag,
                                           input logic [31:0] dst, input int pay,
                                           input int tl_adj, input bit corrupt_sum);
    octet_q_t f;
    int hl;
    int span;
    logic [15:0] tl;
    logic [15:0] csum;
    logic [16:0] acc;
    logic [31:0] src;
    hl = int'(ihl) * 4;
    span = (hl > 20) ? hl : 20;
    tl = 16'(hl + pay + tl_adj);
    src = $urandom;
    for (int i = 0; i < span + pay; i++) f.push_back(8'($urandom));
    f[0] = {ver, ihl};
    f[2] = tl[15:8];
    f[3] = tl[7:0];
    f[6] = frag[15:8];
    f[7] = frag[7:0];
    f[9] = proto;
    f[10] = 8'h00;
    f[11] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      f[12+k] = src[31-8*k -: 8];
      f[16+k] = dst[31-8*k -: 8];
    end
    csum = 16'h0;
    for (int i = 0; i + 1 < hl; i += 2) begin
      acc = {1'b0, csum} + {1'b0, f[i], f[i+1]};
      csum = acc[15:0] + {15'd0, acc[16]};
    end
    csum = ~csum;
    if (corrupt_sum) csum ^= 16'(1 << $urandom_range(15));
    f[10] = csum[15:8];
    f[11] = csum[7:0];
    return f;
  endfunction

  // Mostly well-formed datagrams with random content; the rest broken or noise
  function automatic octet_q_t random_dgram();
    octet_q_t f;
    int pick;
    logic [3:0] ver;
    logic [3:0] ihl;
    logic [7:0] proto;
    logic [15:0] frag;
    logic [31:0] dst;
    int pay;
    int adj;
    bit bad_sum;
    pick = $urandom_range(99);
    ver = ipv4hv_pkg::IP_VERSION;
    ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : ipv4hv_pkg::IHL_MIN;
    case ($urandom_range(4))
      0: proto = ipv4hv_pkg::PROTO_ICMP;
      1: proto = ipv4hv_pkg::PROTO_UDP;
      2: proto = ipv4hv_pkg::PROTO_TCP;
      default: proto = 8'($urandom);
    endcase
    case ($urandom_range(7))
      4: frag = 16'h4000;
      5: frag = 16'h8000;
      6: frag = ipv4hv_pkg::FRAG_MASK & 16'($urandom);
      7: frag = 16'($urandom);
      default: frag = 16'h0;
    endcase
    dst = local_ip_shadow;
    pay = $urandom_range(0, 12);
    adj = ($urandom_range(3) == 0) ? -int'($urandom_range(0, pay)) : 0;
    bad_sum = 1'b0;
    if (pick >= 60 && pick < 68)
      ver = 4'($urandom_range(0, 15)) ^ ipv4hv_pkg::IP_VERSION;
    else if (pick >= 68 && pick < 74)
      ihl = 4'($urandom_range(0, 4));
    else if (pick >= 74 && pick < 82)
      bad_sum = 1'b1;
    else if (pick >= 82 && pick < 88)
      adj = $urandom_range(1) ? pay + 1 + int'($urandom_range(0, 20)) : -(pay + 1);
    else if (pick >= 88 && pick < 94)
      dst = local_ip_shadow ^ (32'h1 << $urandom_range(31));
    f = build_dgram(ver, ihl, proto, frag, dst, pay, adj, bad_sum);
    if (pick >= 94) begin
      if ($urandom_range(1)) begin
        f = f[0:$urandom_range(0, 18)];
      end else begin
        f = {};
        repeat ($urandom_range(1, 48)) f.push_back(8'($urandom));
      end
    end
    return f;
  endfunction

  task automatic test_register_reset();
    logic [31:0] rd;
    apb_xfer(1'b0, 32'h0, rd);
    check_field("local_ip after reset", local_ip_shadow, rd);
  endtask

  task automatic test_header_checks();
    octet_q_t f;
    src_idle_pct = 6;
    sink_idle_pct <= 49;
    set_local_ip(32'hC0A8_0001);
    // frame of a single byte
    send_byte(8'hFF, 1'b1);
    // good header cut one byte short of the minimum
    f = build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                    16'h0, local_ip_shadow, 0, 0, 1'b0);
    send_dgram(f[0:18]);
    f = {};
    repeat (24) f.push_back(8'hFF);
    send_dgram(f);
    f = {};
    repeat (20) f.push_back(8'h00);
    send_dgram(f);
    send_dgram(build_dgram(4'd6, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_TCP, 16'h0,
                           local_ip_shadow, 4, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, 4'd4, ipv4hv_pkg::PROTO_TCP, 16'h0,
                           local_ip_shadow, 4, 0, 1'b0));
    // header claims 60 bytes, frame has 40
    f = build_dgram(ipv4hv_pkg::IP_VERSION, 4'd15, ipv4hv_pkg::PROTO_TCP, 16'h0,
                    local_ip_shadow, 0, 0, 1'b0);
    send_dgram(f[0:39]);
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_TCP,
                           16'h0, local_ip_shadow, 4, 0, 1'b1));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_TCP,
                           16'h0, local_ip_shadow, 4, -5, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_TCP,
                           16'h0, local_ip_shadow, 4, 1, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_TCP,
                           16'h0, 32'hC0A8_0002, 4, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                           16'h2000, local_ip_shadow, 2, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                           16'h1FFF, local_ip_shadow, 2, 0, 1'b0));
    // DF and the reserved flag do not make a fragment
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                           16'h4000, local_ip_shadow, 2, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                           16'h8000, local_ip_shadow, 2, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN,
                           ipv4hv_pkg::PROTO_ICMP, 16'h0, local_ip_shadow, 8, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                           16'h0, local_ip_shadow, 8, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_TCP,
                           16'h0, local_ip_shadow, 8, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, 8'd0, 16'h0,
                           local_ip_shadow, 1, 0, 1'b0));
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, 8'd255, 16'h0,
                           local_ip_shadow, 0, 0, 1'b0));
    // maximal header with options
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, 4'd15, ipv4hv_pkg::PROTO_TCP, 16'h0,
                           local_ip_shadow, 4, 0, 1'b0));
    // link padding beyond the total length
    send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN, ipv4hv_pkg::PROTO_UDP,
                           16'h0, local_ip_shadow, 10, -6, 1'b0));
    settle();
  endtask

  task automatic test_local_ip_extremes();
    logic [31:0] addr;
    src_idle_pct = 6;
    sink_idle_pct <= 49;
    for (int i = 0; i < 2; i++) begin
      addr = (i == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      set_local_ip(addr);
      send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN,
                             ipv4hv_pkg::PROTO_UDP, 16'h0, addr, 3, 0, 1'b0));
      send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN,
                             ipv4hv_pkg::PROTO_UDP, 16'h0, ~addr, 3, 0, 1'b0));
      settle();
    end
  endtask

  task automatic test_report_backpressure();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    set_local_ip(32'h0A00_0001);
    -> hold_start;
    repeat (6)
      send_dgram(build_dgram(ipv4hv_pkg::IP_VERSION, ipv4hv_pkg::IHL_MIN,
                             ipv4hv_pkg::PROTO_TCP, 16'h0, local_ip_shadow, 0, 0, 1'b0));
    settle();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int byte_goal);
    octet_q_t f;
    int sent;
    sent = 0;
    src_idle_pct = src_pct;
    sink_idle_pct <= sink_pct;
    set_local_ip($urandom);
    while (sent < byte_goal) begin
      f = random_dgram();
      send_dgram(f);
      sent += f.size();
    end
    settle();
  endtask

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    frame_if.valid     <= 1'b0;
    frame_if.data_byte <= '0;
    frame_if.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_header_checks();
    test_local_ip_extremes();
    test_report_backpressure();
    test_random_traffic(6, 49, 90);
    test_random_traffic(49, 6, 90);
    test_random_traffic(0, 0, 90);
    settle();
    $display("Run covered %0d bytes, %0d verdicts, %0d local_ip settings", bytes_taken,
             verdicts_seen, ip_settings);
    $display("Verdicts: accept %0d runt %0d ver %0d ihl %0d csum %0d tlen %0d dst %0d frag %0d",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3],
             verdict_hist[4], verdict_hist[5], verdict_hist[6], verdict_hist[7]);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
